FILE: hw/rtl/dnsp_pkg.sv
// Shared types and constants for the DNS message stream parser.
package dnsp_pkg;

  localparam int HEADER_LAST_BYTE = 11;
  localparam int QFIXED_LAST_BYTE = 3;
  localparam int AFIXED_LAST_BYTE = 9;
  localparam int LABEL_CNT_W      = 4;

  localparam logic [1:0] KIND_HEADER   = 2'd0;
  localparam logic [1:0] KIND_QUESTION = 2'd1;
  localparam logic [1:0] KIND_ANSWER   = 2'd2;
  localparam logic [1:0] KIND_BAD      = 2'd3;

  // Packed so transaction_id sits in the lowest bits of the bus.
  typedef struct packed {
    logic [15:0] data_length;
    logic [31:0] time_to_live;
    logic [15:0] rr_class;
    logic [15:0] rr_type;
    logic [15:0] answer_count;
    logic [15:0] question_count;
    logic [3:0]  reply_code;
    logic [6:0]  flag_bits;
    logic [3:0]  opcode;
    logic        is_response;
    logic [15:0] transaction_id;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

endpackage

FILE: hw/rtl/dns_message_stream_parser.sv
// DNS message stream parser: header, question and answer record walker.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+-----------------------------------
//  s_axis  | in  | s_axis_tvalid/tready   | tdata: data_byte; tlast: end_of_message
//  m_axis  | out | m_axis_tvalid/tready   | tdata: result fields; tuser: record_kind
//
// Each byte is parsed in the cycle it is accepted; any result lands in the
// output register in the next cycle. One byte per cycle is sustained, set by
// the single output register: a byte is taken whenever that register is
// empty or being drained in the same cycle. A stall on m_axis holds the
// result and deasserts s_axis_tready. rst (synchronous) returns the parser
// to the header phase and empties the output register.
module dns_message_stream_parser #(
  parameter int MAX_LABELS = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,  // [7:0] data_byte
  input  logic                         s_axis_tlast,  // end_of_message
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // [15:0] transaction_id, [16] is_response, [20:17] opcode, [27:21] flag_bits,
  // [31:28] reply_code, [47:32] question_count, [63:48] answer_count,
  // [79:64] rr_type, [95:80] rr_class, [127:96] time_to_live,
  // [143:128] data_length
  output logic [dnsp_pkg::RESULT_W-1:0] m_axis_tdata,
  output logic [1:0]                   m_axis_tuser   // [1:0] record_kind
);
  import dnsp_pkg::*;

  // Parse phases
  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_QNAME  = 4'd1;
  localparam logic [3:0] PH_QFIXED = 4'd2;
  localparam logic [3:0] PH_ANAME  = 4'd3;
  localparam logic [3:0] PH_AFIXED = 4'd4;
  localparam logic [3:0] PH_RDATA  = 4'd5;
  localparam logic [3:0] PH_QPTR   = 4'd6;
  localparam logic [3:0] PH_APTR   = 4'd7;
  localparam logic [3:0] PH_DONE   = 4'd8;
  localparam logic [3:0] PH_BAD    = 4'd9;

  localparam logic [LABEL_CNT_W-1:0] LABEL_LIMIT = LABEL_CNT_W'(MAX_LABELS);

  // Parser state
  logic [3:0]             phase, phase_next;
  logic [3:0]             fbc, fbc_next;
  logic [15:0]            txn, txn_next;
  logic [15:0]            flags, flags_next;
  logic [15:0]            qleft, qleft_next;
  logic [15:0]            aleft, aleft_next;
  logic [15:0]            qann, qann_next;
  logic [15:0]            aann, aann_next;
  logic [LABEL_CNT_W-1:0] labels, labels_next;
  logic [7:0]             lbl_left, lbl_left_next;
  logic [15:0]            rtype, rtype_next;
  logic [15:0]            rclass, rclass_next;
  logic [31:0]            ttl, ttl_next;
  logic [15:0]            rdata_left, rdata_left_next;

  logic       accept;
  logic       emit;
  logic [1:0] kind;
  logic       sect;
  logic [15:0] out_type, out_class, out_dlen;
  logic [31:0] out_ttl;
  logic [7:0]  b;
  result_t     res;

  assign b             = s_axis_tdata;
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    phase_next      = phase;
    fbc_next        = fbc;
    txn_next        = txn;
    flags_next      = flags;
    qleft_next      = qleft;
    aleft_next      = aleft;
    qann_next       = qann;
    aann_next       = aann;
    labels_next     = labels;
    lbl_left_next   = lbl_left;
    rtype_next      = rtype;
    rclass_next     = rclass;
    ttl_next        = ttl;
    rdata_left_next = rdata_left;
    emit      = 1'b0;
    kind      = KIND_HEADER;
    sect      = 1'b0;
    out_type  = '0;
    out_class = '0;
    out_ttl   = '0;
    out_dlen  = '0;

    unique case (phase)
      PH_HEADER: begin
        // Big-endian header fields; the last four bytes are counts we skip.
        case (fbc)
          4'd0: txn_next = txn | {b, 8'h00};
          4'd1: txn_next = txn | {8'h00, b};
          4'd2: flags_next = flags | {b, 8'h00};
          4'd3: flags_next = flags | {8'h00, b};
          4'd4: begin
            qleft_next = qleft | {b, 8'h00};
            qann_next  = qann | {b, 8'h00};
          end
          4'd5: begin
            qleft_next = qleft | {8'h00, b};
            qann_next  = qann | {8'h00, b};
          end
          4'd6: begin
            aleft_next = aleft | {b, 8'h00};
            aann_next  = aann | {b, 8'h00};
          end
          4'd7: begin
            aleft_next = aleft | {8'h00, b};
            aann_next  = aann | {8'h00, b};
          end
          default: ;
        endcase
        fbc_next = fbc + 4'd1;
        if (fbc == 4'(HEADER_LAST_BYTE)) begin
          emit = 1'b1;
          kind = KIND_HEADER;
          sect = 1'b1;
        end
      end
      PH_QNAME, PH_ANAME: begin
        if (lbl_left != 8'd0) begin
          lbl_left_next = lbl_left - 8'd1;
        end else if (b == 8'd0) begin
          fbc_next   = '0;
          phase_next = (phase == PH_QNAME) ? PH_QFIXED : PH_AFIXED;
        end else if (b[7:6] == 2'b11) begin
          // Compression pointer: one more byte, not followed
          phase_next = (phase == PH_QNAME) ? PH_QPTR : PH_APTR;
        end else if (b[7:6] != 2'b00 || labels >= LABEL_LIMIT) begin
          emit       = 1'b1;
          kind       = KIND_BAD;
          phase_next = PH_BAD;
        end else begin
          labels_next   = labels + LABEL_CNT_W'(1);
          lbl_left_next = b;
        end
      end
      PH_QPTR: begin
        fbc_next   = '0;
        phase_next = PH_QFIXED;
      end
      PH_APTR: begin
        fbc_next   = '0;
        phase_next = PH_AFIXED;
      end
      PH_QFIXED: begin
        if (fbc < 4'd2) rtype_next = {rtype[7:0], b};
        else            rclass_next = {rclass[7:0], b};
        fbc_next = fbc + 4'd1;
        if (fbc == 4'(QFIXED_LAST_BYTE)) begin
          emit       = 1'b1;
          kind       = KIND_QUESTION;
          out_type   = rtype_next;
          out_class  = rclass_next;
          qleft_next = qleft - 16'd1;
          sect       = 1'b1;
        end
      end
      PH_AFIXED: begin
        if (fbc < 4'd2)      rtype_next = {rtype[7:0], b};
        else if (fbc < 4'd4) rclass_next = {rclass[7:0], b};
        else if (fbc < 4'd8) ttl_next = {ttl[23:0], b};
        else                 rdata_left_next = {rdata_left[7:0], b};
        fbc_next = fbc + 4'd1;
        if (fbc == 4'(AFIXED_LAST_BYTE)) begin
          emit       = 1'b1;
          kind       = KIND_ANSWER;
          out_type   = rtype_next;
          out_class  = rclass_next;
          out_ttl    = ttl_next;
          out_dlen   = rdata_left_next;
          aleft_next = aleft - 16'd1;
          if (rdata_left_next != 16'd0) begin
            phase_next = PH_RDATA;
            fbc_next   = '0;
          end else begin
            sect = 1'b1;
          end
        end
      end
      PH_RDATA: begin
        // Skip answer data
        rdata_left_next = rdata_left - 16'd1;
        if (rdata_left_next == 16'd0) sect = 1'b1;
      end
      default: ;  // done or bad: drop bytes until the end mark
    endcase

    // Advance to the next record, or finish the message
    if (sect) begin
      fbc_next      = '0;
      labels_next   = '0;
      lbl_left_next = '0;
      rtype_next    = '0;
      rclass_next   = '0;
      ttl_next      = '0;
      if (qleft_next != 16'd0)      phase_next = PH_QNAME;
      else if (aleft_next != 16'd0) phase_next = PH_ANAME;
      else                          phase_next = PH_DONE;
    end

    // Result fields read the header stores as updated by this byte
    res.transaction_id = txn_next;
    res.is_response    = flags_next[15];
    res.opcode         = flags_next[14:11];
    res.flag_bits      = flags_next[10:4];
    res.reply_code     = flags_next[3:0];
    res.question_count = qann_next;
    res.answer_count   = aann_next;
    res.rr_type        = out_type;
    res.rr_class       = out_class;
    res.time_to_live   = out_ttl;
    res.data_length    = out_dlen;

    if (s_axis_tlast) begin
      // Early end replaces whatever this byte would have produced
      if (phase_next != PH_DONE && phase_next != PH_BAD) begin
        emit             = 1'b1;
        kind             = KIND_BAD;
        res.rr_type      = '0;
        res.rr_class     = '0;
        res.time_to_live = '0;
        res.data_length  = '0;
      end
      phase_next      = PH_HEADER;
      fbc_next        = '0;
      txn_next        = '0;
      flags_next      = '0;
      qleft_next      = '0;
      aleft_next      = '0;
      qann_next       = '0;
      aann_next       = '0;
      labels_next     = '0;
      lbl_left_next   = '0;
      rtype_next      = '0;
      rclass_next     = '0;
      ttl_next        = '0;
      rdata_left_next = '0;
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HEADER;
      fbc        <= '0;
      txn        <= '0;
      flags      <= '0;
      qleft      <= '0;
      aleft      <= '0;
      qann       <= '0;
      aann       <= '0;
      labels     <= '0;
      lbl_left   <= '0;
      rtype      <= '0;
      rclass     <= '0;
      ttl        <= '0;
      rdata_left <= '0;
    end else if (accept) begin
      phase      <= phase_next;
      fbc        <= fbc_next;
      txn        <= txn_next;
      flags      <= flags_next;
      qleft      <= qleft_next;
      aleft      <= aleft_next;
      qann       <= qann_next;
      aann       <= aann_next;
      labels     <= labels_next;
      lbl_left   <= lbl_left_next;
      rtype      <= rtype_next;
      rclass     <= rclass_next;
      ttl        <= ttl_next;
      rdata_left <= rdata_left_next;
    end
  end

  // Output register: load a result on each producing transaction, else drop on drain
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      m_axis_tdata <= res;
      m_axis_tuser <= kind;
    end
  end

endmodule
